### hw/rtl/swnws_pkg.sv
package swnws_pkg;

	localparam int POSITION_WIDTH = 48;
	localparam int FRACTION_BITS  = 16;
	localparam int QUEUE_DEPTH    = 4;
	localparam int SWING_WIDTH    = 16;
	localparam int CFG_IDX_WIDTH  = 2;
	localparam int OUT_DATA_WIDTH = 16;

	localparam logic [SWING_WIDTH-1:0] SWING_LIMIT = 16'd39321;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_SIXTEENTH = 2'd0,
		REG_SWING     = 2'd1
	} cfg_reg_t;

endpackage

### hw/rtl/swing_note_window_scheduler.sv
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tdata notes + window, s_tuser midi flags
// m_      | out | m_tvalid/m_tready  | m_tdata pitch/velocity, m_tlast last event
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// One note beat accepted per cycle while the queue has room; each note yields zero,
// one or two event beats, through the queue and the one-bit-per-stage step divider.
// Sustained rate, while m_tready is high: one note or one emitted event beat per cycle.
// arst_n clears control state and both registers; no clearing pass.
// A stalled m_ side holds the back pipeline; the queue lets the front keep taking notes.
module swing_note_window_scheduler #(
	parameter int POSITION_WIDTH = swnws_pkg::POSITION_WIDTH,
	parameter int FRACTION_BITS  = swnws_pkg::FRACTION_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// clip_start, note_offset, note_length, pitch, velocity, clip_lane,
	// track_lane, window_start, block_length, zero fill
	input  logic [((4*POSITION_WIDTH+46+7)/8)*8-1:0] s_tdata,
	// clip_is_midi, track_is_midi
	input  logic [1:0]                           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// event_pitch, event_velocity, zero fill
	output logic [swnws_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
	output logic                                 m_tlast,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [swnws_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [POSITION_WIDTH-1:0]            cfg_data
);

	localparam int IN_WIDTH    = ((4*POSITION_WIDTH+46+7)/8)*8;
	localparam int QUEUE_WIDTH = 3*POSITION_WIDTH + 46;

	logic [POSITION_WIDTH-1:0]         sixteenth_q;
	logic [swnws_pkg::SWING_WIDTH-1:0] swing_q;
	logic                              fq_valid;
	logic                              fq_ready;
	logic [QUEUE_WIDTH-1:0]            fq_data;
	logic                              qb_valid;
	logic                              qb_ready;
	logic [QUEUE_WIDTH-1:0]            qb_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sixteenth_q <= '0;
			swing_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				swnws_pkg::REG_SIXTEENTH: sixteenth_q <= cfg_data;
				swnws_pkg::REG_SWING:     swing_q     <= cfg_data[swnws_pkg::SWING_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	swnws_front #(
		.POSITION_WIDTH(POSITION_WIDTH),
		.IN_WIDTH      (IN_WIDTH),
		.QUEUE_WIDTH   (QUEUE_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_valid (fq_valid),
		.q_ready (fq_ready),
		.q_data  (fq_data)
	);

	swnws_queue #(
		.WIDTH(QUEUE_WIDTH),
		.DEPTH(swnws_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fq_valid),
		.in_ready (fq_ready),
		.in_data  (fq_data),
		.out_valid(qb_valid),
		.out_ready(qb_ready),
		.out_data (qb_data)
	);

	swnws_back #(
		.POSITION_WIDTH(POSITION_WIDTH),
		.FRACTION_BITS (FRACTION_BITS),
		.QUEUE_WIDTH   (QUEUE_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.sixteenth(sixteenth_q),
		.swing    (swing_q),
		.q_valid  (qb_valid),
		.q_ready  (qb_ready),
		.q_data   (qb_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

### hw/rtl/swnws_front.sv
module swnws_front #(
	parameter int POSITION_WIDTH = swnws_pkg::POSITION_WIDTH,
	parameter int IN_WIDTH       = 240,
	parameter int QUEUE_WIDTH    = 190
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_WIDTH-1:0]    s_tdata,
	input  logic [1:0]             s_tuser,
	output logic                   q_valid,
	input  logic                   q_ready,
	output logic [QUEUE_WIDTH-1:0] q_data
);

	localparam int W = POSITION_WIDTH;

	logic [W-1:0]           clip_start;
	logic [W-1:0]           note_offset;
	logic [W-1:0]           note_length;
	logic [6:0]             pitch;
	logic [6:0]             velocity;
	logic [7:0]             clip_lane;
	logic [7:0]             track_lane;
	logic [W-1:0]           window_start;
	logic [15:0]            block_length;
	logic [W:0]             pos_sum;
	logic [W-1:0]           pos;
	logic                   pass;
	logic                   adv;
	logic                   v_s1;
	logic [QUEUE_WIDTH-1:0] pay_s1;

	assign clip_start   = s_tdata[W-1:0];
	assign note_offset  = s_tdata[2*W-1:W];
	assign note_length  = s_tdata[3*W-1:2*W];
	assign pitch        = s_tdata[3*W+6:3*W];
	assign velocity     = s_tdata[3*W+13:3*W+7];
	assign clip_lane    = s_tdata[3*W+21:3*W+14];
	assign track_lane   = s_tdata[3*W+29:3*W+22];
	assign window_start = s_tdata[4*W+29:3*W+30];
	assign block_length = s_tdata[4*W+45:4*W+30];

	assign pos_sum = {1'b0, clip_start} + {1'b0, note_offset};
	assign pos     = pos_sum[W] ? {W{1'b1}} : pos_sum[W-1:0];
	assign pass    = s_tuser[0] && s_tuser[1] && (clip_lane == track_lane);

	assign adv      = !v_s1 || q_ready;
	assign s_tready = adv;
	assign q_valid  = v_s1;
	assign q_data   = pay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid && pass;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_s1 <= {block_length, window_start, velocity, pitch, note_length, pos};
		end
	end

endmodule

### hw/rtl/swnws_queue.sv
module swnws_queue #(
	parameter int WIDTH = 190,
	parameter int DEPTH = swnws_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             push;
	logic             pop;

	assign in_ready  = count_q != (AW+1)'(DEPTH);
	assign out_valid = count_q != '0;
	assign out_data  = mem[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= in_data;
		end
	end

endmodule

### hw/rtl/swnws_back.sv
module swnws_back #(
	parameter int POSITION_WIDTH = swnws_pkg::POSITION_WIDTH,
	parameter int FRACTION_BITS  = swnws_pkg::FRACTION_BITS,
	parameter int QUEUE_WIDTH    = 190
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic [POSITION_WIDTH-1:0]                  sixteenth,
	input  logic [swnws_pkg::SWING_WIDTH-1:0]          swing,
	input  logic                                       q_valid,
	output logic                                       q_ready,
	input  logic [QUEUE_WIDTH-1:0]                     q_data,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	output logic [swnws_pkg::OUT_DATA_WIDTH-1:0]       m_tdata,
	output logic                                       m_tlast
);

	localparam int W  = POSITION_WIDTH;
	localparam int LQ = 16 + FRACTION_BITS;
	localparam int CW = (W > LQ) ? W : LQ;

	function automatic logic in_win(input logic [W-1:0] x, input logic [W-1:0] bs,
			input logic [15:0] bl);
		logic [CW-1:0] d;
		logic [CW-1:0] lq;
		d  = CW'(x - bs);
		lq = CW'(bl) << FRACTION_BITS;
		return (x >= bs) && (d < lq);
	endfunction

	// swing delay from the registers
	logic [swnws_pkg::SWING_WIDTH-1:0] swc;
	logic [W-1:0]                      hi_prod;
	logic [31:0]                       lo_prod;
	logic [W-1:0]                      delay_q;

	assign swc     = (swing > swnws_pkg::SWING_LIMIT) ? swnws_pkg::SWING_LIMIT : swing;
	assign hi_prod = {16'd0, sixteenth[W-1:16]} * {{(W-16){1'b0}}, swc};
	assign lo_prod = {16'd0, sixteenth[15:0]} * {16'd0, swc};

	always_ff @(posedge clk) begin
		if (swing == '0 || sixteenth == '0) begin
			delay_q <= '0;
		end else begin
			delay_q <= hi_prod + W'(lo_prod[31:16]);
		end
	end

	logic adv;

	// restoring divider, one quotient bit per stage
	logic                   dv_s  [W];
	logic [W-1:0]           rem_s [W];
	logic [QUEUE_WIDTH-1:0] pay_s [W];
	logic                   qb_s  [W];

	assign q_ready = adv;

	for (genvar k = 0; k < W; k++) begin : g_div
		logic                   vin;
		logic [W-1:0]           rin;
		logic [QUEUE_WIDTH-1:0] pin;
		logic [W:0]             t;
		logic [W:0]             diff;
		logic                   ge;

		if (k == 0) begin : g_first
			assign vin = q_valid;
			assign rin = '0;
			assign pin = q_data;
		end else begin : g_next
			assign vin = dv_s[k-1];
			assign rin = rem_s[k-1];
			assign pin = pay_s[k-1];
		end

		assign t    = {rin, pin[W-1-k]};
		assign diff = t - {1'b0, sixteenth};
		assign ge   = t >= {1'b0, sixteenth};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k] <= 1'b0;
			end else if (adv) begin
				dv_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= ge ? diff[W-1:0] : t[W-1:0];
				pay_s[k] <= pin;
				qb_s[k]  <= ge;
			end
		end
	end

	logic [QUEUE_WIDTH-1:0] last_pay;
	logic [W-1:0]           d_pos;
	logic [W:0]             on_sum;
	logic                   v_s1;
	logic                   v_s2;
	logic                   v_s3;
	logic [QUEUE_WIDTH-1:0] pay_s1;
	logic [QUEUE_WIDTH-1:0] pay_s2;
	logic [W-1:0]           on_s1;
	logic [W-1:0]           off_s2;
	logic [W:0]             off_sum;
	logic                   on_hit_s2;
	logic                   on_hit_s3;
	logic                   off_hit_s3;
	logic [6:0]             pit_s3;
	logic [6:0]             vel_s3;

	assign last_pay = pay_s[W-1];
	assign d_pos    = last_pay[W-1:0];
	assign on_sum   = {1'b0, d_pos} + {1'b0, (qb_s[W-1] ? delay_q : {W{1'b0}})};
	assign off_sum  = {1'b0, on_s1} + {1'b0, pay_s1[2*W-1:W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= dv_s[W-1];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_s1     <= last_pay;
			on_s1      <= on_sum[W] ? {W{1'b1}} : on_sum[W-1:0];
			pay_s2     <= pay_s1;
			off_s2     <= off_sum[W] ? {W{1'b1}} : off_sum[W-1:0];
			on_hit_s2  <= in_win(on_s1, pay_s1[3*W+13:2*W+14], pay_s1[3*W+29:3*W+14]);
			on_hit_s3  <= on_hit_s2;
			off_hit_s3 <= in_win(off_s2, pay_s2[3*W+13:2*W+14], pay_s2[3*W+29:3*W+14]);
			pit_s3     <= pay_s2[2*W+6:2*W];
			vel_s3     <= pay_s2[2*W+13:2*W+7];
		end
	end

	// event output: up to two beats per note
	logic       has_q;
	logic       on_beat_q;
	logic       two_q;
	logic [6:0] pit_q;
	logic [6:0] vel_q;
	logic       last;
	logic       free;
	logic       load;

	assign last = !(on_beat_q && two_q);
	assign free = !has_q || (m_tready && last);
	assign adv  = !v_s3 || free;
	assign load = v_s3 && free && (on_hit_s3 || off_hit_s3);

	assign m_tvalid = has_q;
	assign m_tlast  = last;
	assign m_tdata  = {2'b00, (on_beat_q ? vel_q : 7'd0), pit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_q     <= 1'b0;
			on_beat_q <= 1'b0;
			two_q     <= 1'b0;
		end else if (load) begin
			has_q     <= 1'b1;
			on_beat_q <= on_hit_s3;
			two_q     <= on_hit_s3 && off_hit_s3;
		end else if (has_q && m_tready) begin
			if (last) begin
				has_q <= 1'b0;
			end else begin
				on_beat_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pit_q <= pit_s3;
			vel_q <= vel_s3;
		end
	end

endmodule

### hw/rtl/swnws_checker.sv
module swnws_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [swnws_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
	input logic                                 m_tlast
);

	// hold a stalled event beat
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("event beat dropped while stalled");

	// a note-on that is not last is followed at once by its note-off
	a_off_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast && (m_tdata[13:7] == 7'd0))
		else $error("note-off missing after note-on");

	a_same_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tdata[6:0] == $past(m_tdata[6:0]))
		else $error("note-off pitch differs from note-on");

endmodule

bind swing_note_window_scheduler swnws_checker u_swnws_checker (.*);
